// ===== src/hpmf_pkg.sv =====
// ----------------------------------------------------------------------------
// hpmf_pkg
// shared types and constants of the homography pixel map and flow block
// ----------------------------------------------------------------------------
package hpmf_pkg;

  localparam int COEF_W   = 48;
  localparam int IDX_W    = 4;
  localparam int NUM_COEF = 9;
  localparam int OUT_W    = 24;
  localparam int QBITS    = 24;

  localparam logic [COEF_W-1:0] ONE_Q32 = 48'h0001_0000_0000;
  localparam logic [OUT_W-1:0]  OUT_MAX = 24'h7F_FFFF;
  localparam logic [OUT_W-1:0]  OUT_MIN = 24'h80_0000;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_MAP  = 1'b1
  } op_e;

endpackage

// ===== src/homography_pixel_map_and_flow.sv =====
// ----------------------------------------------------------------------------
// homography_pixel_map_and_flow
// perspective map of a pixel through a 3x3 homography, with flow and a
// saturation flag
// ----------------------------------------------------------------------------
// load transfers give no result and take effect for every map transfer
// that follows them; throughput: one item per cycle unless out_stall_i
// holds it back, set by the 29-stage pipeline (multiply, sum, magnitude,
// range check, 24 one-bit divide steps, output)
// stages move on only into empty or emptying slots, so bubbles close up
// reset: pipeline empty, coefficient table holds the identity matrix
module homography_pixel_map_and_flow #(
  parameter int COORD_BITS    = 12,
  parameter int OUT_FRAC_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               op_i,
  input  logic [hpmf_pkg::IDX_W-1:0]         coef_index_i,
  input  logic signed [hpmf_pkg::COEF_W-1:0] coef_value_i,
  input  logic [COORD_BITS-1:0]              pixel_col_i,
  input  logic [COORD_BITS-1:0]              pixel_row_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [hpmf_pkg::OUT_W-1:0]  map_x_o,
  output logic signed [hpmf_pkg::OUT_W-1:0]  map_y_o,
  output logic signed [hpmf_pkg::OUT_W-1:0]  flow_x_o,
  output logic signed [hpmf_pkg::OUT_W-1:0]  flow_y_o,
  output logic                               invalid_o
);

  localparam int CW  = hpmf_pkg::COEF_W;
  localparam int OW  = hpmf_pkg::OUT_W;
  localparam int QB  = hpmf_pkg::QBITS;
  localparam int PW  = CW + COORD_BITS + 1;
  localparam int SW  = PW + 2;
  localparam int RW  = SW + OUT_FRAC_BITS + QB;
  // flow needs room for the scaled pixel and the 24-bit map value
  localparam int FW  = ((COORD_BITS + OUT_FRAC_BITS > OW) ?
                        COORD_BITS + OUT_FRAC_BITS : OW) + 2;
  localparam int ND  = QB + 2;
  localparam int NS  = ND + 3;
  localparam int OUT_ST = NS - 1;
  localparam int IDX_BITS = hpmf_pkg::IDX_W;

  typedef struct packed {
    logic [RW-1:0]         rx;
    logic [RW-1:0]         ry;
    logic [SW-1:0]         den;
    logic [QB-1:0]         qx;
    logic [QB-1:0]         qy;
    logic                  bx;
    logic                  by;
    logic                  nx;
    logic                  ny;
    logic                  xneg;
    logic                  yneg;
    logic                  wz;
    logic [COORD_BITS-1:0] c;
    logic [COORD_BITS-1:0] r;
  } div_t;

  // coefficient table
  logic signed [CW-1:0] coef_q [hpmf_pkg::NUM_COEF];

  logic accept;
  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hpmf_pkg::NUM_COEF; i++) begin
        coef_q[i] <= (i == 0 || i == 4 || i == 8) ? hpmf_pkg::ONE_Q32 : '0;
      end
    end else if (accept && op_i == hpmf_pkg::OP_LOAD) begin
      for (int i = 0; i < hpmf_pkg::NUM_COEF; i++) begin
        if (coef_index_i == IDX_BITS'(i)) begin
          coef_q[i] <= coef_value_i;
        end
      end
    end
  end

  // valid bits and movement
  logic [NS-1:0] v_q;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !v_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i && op_i == hpmf_pkg::OP_MAP;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 1: products
  logic signed [COORD_BITS:0] cs, rs;
  assign cs = $signed({1'b0, pixel_col_i});
  assign rs = $signed({1'b0, pixel_row_i});

  logic signed [PW-1:0] p_d [6];
  always_comb begin
    p_d[0] = coef_q[0] * cs;
    p_d[1] = coef_q[1] * rs;
    p_d[2] = coef_q[3] * cs;
    p_d[3] = coef_q[4] * rs;
    p_d[4] = coef_q[6] * cs;
    p_d[5] = coef_q[7] * rs;
  end

  logic signed [PW-1:0]  p_q [6];
  logic signed [CW-1:0]  k_q [3];
  logic [COORD_BITS-1:0] c1_q, r1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      p_q  <= p_d;
      k_q[0] <= coef_q[2];
      k_q[1] <= coef_q[5];
      k_q[2] <= coef_q[8];
      c1_q <= pixel_col_i;
      r1_q <= pixel_row_i;
    end
  end

  // stage 2: affine sums
  logic signed [SW-1:0]  s_q [3];
  logic [COORD_BITS-1:0] c2_q, r2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      for (int j = 0; j < 3; j++) begin
        s_q[j] <= $signed({{2{p_q[2*j][PW-1]}}, p_q[2*j]})
                + $signed({{2{p_q[2*j+1][PW-1]}}, p_q[2*j+1]})
                + $signed({{(SW-CW){k_q[j][CW-1]}}, k_q[j]});
      end
      c2_q <= c1_q;
      r2_q <= r1_q;
    end
  end

  // divider stages: magnitudes, range check, then one quotient bit each
  div_t dv_q [ND];
  div_t dv_n [ND];

  logic [SW-1:0] mag_x, mag_y, mag_w;
  assign mag_x = s_q[0][SW-1] ? SW'(-s_q[0]) : SW'(s_q[0]);
  assign mag_y = s_q[1][SW-1] ? SW'(-s_q[1]) : SW'(s_q[1]);
  assign mag_w = s_q[2][SW-1] ? SW'(-s_q[2]) : SW'(s_q[2]);

  always_comb begin
    dv_n[0]      = '0;
    dv_n[0].rx   = RW'(mag_x) << OUT_FRAC_BITS;
    dv_n[0].ry   = RW'(mag_y) << OUT_FRAC_BITS;
    dv_n[0].den  = mag_w;
    dv_n[0].nx   = s_q[0][SW-1] ^ s_q[2][SW-1];
    dv_n[0].ny   = s_q[1][SW-1] ^ s_q[2][SW-1];
    dv_n[0].xneg = s_q[0][SW-1];
    dv_n[0].yneg = s_q[1][SW-1];
    dv_n[0].wz   = (s_q[2] == '0);
    dv_n[0].c    = c2_q;
    dv_n[0].r    = r2_q;
  end

  // quotient of 2^24 or more saturates
  always_comb begin
    dv_n[1]    = dv_q[0];
    dv_n[1].bx = dv_q[0].rx >= (RW'(dv_q[0].den) << QB);
    dv_n[1].by = dv_q[0].ry >= (RW'(dv_q[0].den) << QB);
  end

  for (genvar k = 2; k < ND; k++) begin : g_step
    localparam int BIT = ND - 1 - k;
    logic [RW:0] tx, ty;
    always_comb begin
      tx = {1'b0, dv_q[k-1].rx} - {1'b0, RW'(dv_q[k-1].den) << BIT};
      ty = {1'b0, dv_q[k-1].ry} - {1'b0, RW'(dv_q[k-1].den) << BIT};
      dv_n[k] = dv_q[k-1];
      if (!tx[RW]) begin
        dv_n[k].rx      = tx[RW-1:0];
        dv_n[k].qx[BIT] = 1'b1;
      end
      if (!ty[RW]) begin
        dv_n[k].ry      = ty[RW-1:0];
        dv_n[k].qy[BIT] = 1'b1;
      end
    end
  end

  for (genvar k = 0; k < ND; k++) begin : g_dreg
    always_ff @(posedge clk_i) begin
      if (rdy[k+2]) begin
        dv_q[k] <= dv_n[k];
      end
    end
  end

  // output stage: sign, saturation and flow
  div_t dl;
  assign dl = dv_q[ND-1];

  logic [OW-1:0] mx, my, fx, fy;
  logic          sat;
  logic signed [FW-1:0] fxw, fyw;

  always_comb begin
    sat = 1'b0;
    if (dl.wz) begin
      sat = 1'b1;
      mx  = dl.xneg ? hpmf_pkg::OUT_MIN : hpmf_pkg::OUT_MAX;
      my  = dl.yneg ? hpmf_pkg::OUT_MIN : hpmf_pkg::OUT_MAX;
    end else begin
      if (dl.nx) begin
        if (dl.bx || dl.qx > hpmf_pkg::OUT_MIN) begin
          mx  = hpmf_pkg::OUT_MIN;
          sat = 1'b1;
        end else begin
          mx = OW'(-dl.qx);
        end
      end else if (dl.bx || dl.qx[QB-1]) begin
        mx  = hpmf_pkg::OUT_MAX;
        sat = 1'b1;
      end else begin
        mx = dl.qx;
      end
      if (dl.ny) begin
        if (dl.by || dl.qy > hpmf_pkg::OUT_MIN) begin
          my  = hpmf_pkg::OUT_MIN;
          sat = 1'b1;
        end else begin
          my = OW'(-dl.qy);
        end
      end else if (dl.by || dl.qy[QB-1]) begin
        my  = hpmf_pkg::OUT_MAX;
        sat = 1'b1;
      end else begin
        my = dl.qy;
      end
    end

    fxw = $signed(FW'(dl.c) << OUT_FRAC_BITS) - $signed({{(FW-OW){mx[OW-1]}}, mx});
    fyw = $signed(FW'(dl.r) << OUT_FRAC_BITS) - $signed({{(FW-OW){my[OW-1]}}, my});

    // out of range when the bits above the 24-bit sign disagree
    if (fxw[FW-1:OW-1] != {(FW-OW+1){fxw[FW-1]}}) begin
      fx  = fxw[FW-1] ? hpmf_pkg::OUT_MIN : hpmf_pkg::OUT_MAX;
      sat = 1'b1;
    end else begin
      fx = fxw[OW-1:0];
    end
    if (fyw[FW-1:OW-1] != {(FW-OW+1){fyw[FW-1]}}) begin
      fy  = fyw[FW-1] ? hpmf_pkg::OUT_MIN : hpmf_pkg::OUT_MAX;
      sat = 1'b1;
    end else begin
      fy = fyw[OW-1:0];
    end
  end

  logic [OW-1:0] mx_q, my_q, fx_q, fy_q;
  logic          sat_q;

  always_ff @(posedge clk_i) begin
    if (rdy[OUT_ST]) begin
      mx_q  <= mx;
      my_q  <= my;
      fx_q  <= fx;
      fy_q  <= fy;
      sat_q <= sat;
    end
  end

  assign out_valid_o = v_q[OUT_ST];
  assign map_x_o     = $signed(mx_q);
  assign map_y_o     = $signed(my_q);
  assign flow_x_o    = $signed(fx_q);
  assign flow_y_o    = $signed(fy_q);
  assign invalid_o   = sat_q;

endmodule
